[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/cch_pkg.sv]
// ----------------------------------------------------------------------------
// cch_pkg
// Types and constants of the 5x5 sharpening filter with output histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package cch_pkg;

  // Input item commands
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  // Result item kinds
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_BIN   = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 9;
  localparam int CNT_W  = 32;
  localparam int BIN_W  = 8;
  localparam int BINS   = 256;
  localparam int WREG_W = 10;
  localparam int HREG_W = 12;
  localparam int CFG_W  = 12;
  localparam int KSIZE  = 5;
  localparam int LINES  = 4;
  localparam int MARGIN = 4;
  localparam int MIN_DIM = 5;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = 10'd300;
  localparam logic [HREG_W-1:0] HEIGHT_RESET = 12'd300;

  typedef struct packed {
    cmd_t             command;
    logic [PIX_W-1:0] pixel;
    logic [BIN_W-1:0] bin_index;
  } in_t;

  typedef struct packed {
    kind_t            kind;
    logic [PIX_W-1:0] filtered_pixel;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_end;
    logic [CNT_W-1:0] bin_count;
  } out_t;

  // Histogram access request, registered in the histogram ahead of its result
  typedef struct packed {
    logic             valid;
    logic             incr;
    logic [BIN_W-1:0] addr;
  } hist_req_t;

endpackage

`default_nettype wire

[src/cch_hist.sv]
// ----------------------------------------------------------------------------
// cch_hist
// 256-bin saturating histogram: registered read, modify, write back.
// ----------------------------------------------------------------------------
`default_nettype none

module cch_hist (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     adv,
  input  wire cch_pkg::hist_req_t       req,
  output logic [cch_pkg::CNT_W-1:0]     count
);

  logic [cch_pkg::CNT_W-1:0] mem [cch_pkg::BINS];
  logic [cch_pkg::CNT_W-1:0] q;
  logic                      vbit_q;
  logic [cch_pkg::BINS-1:0]  vld;
  cch_pkg::hist_req_t        cur;
  logic                      fwd_v;
  logic [cch_pkg::BIN_W-1:0] fwd_addr;
  logic [cch_pkg::CNT_W-1:0] fwd_data;
  logic [cch_pkg::CNT_W-1:0] eff;
  logic [cch_pkg::CNT_W-1:0] count_next;
  logic                      wr;

  // Pick the freshest value: bypass the write made on the read edge
  always_comb begin
    if (fwd_v && fwd_addr == cur.addr) begin
      eff = fwd_data;
    end else if (vbit_q) begin
      eff = q;
    end else begin
      eff = '0;
    end
    count_next = (&eff) ? eff : eff + cch_pkg::CNT_W'(1);
    wr         = cur.valid && cur.incr;
  end

  assign count = eff;

  // Memory read and write back
  always_ff @(posedge clk) begin
    if (adv) begin
      q <= mem[req.addr];
      if (wr) begin
        mem[cur.addr] <= count_next;
      end
    end
  end

  // Forward data, no reset needed
  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr <= cur.addr;
      fwd_data <= count_next;
    end
  end

  // Control: valid bits, stage request, bypass valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      vbit_q    <= 1'b0;
      cur.valid <= 1'b0;
      fwd_v     <= 1'b0;
    end else if (adv) begin
      vbit_q    <= vld[req.addr];
      cur       <= req;
      fwd_v     <= wr;
      if (wr) begin
        vld[cur.addr] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/conv5x5_clamp_histogram_top.sv]
// ----------------------------------------------------------------------------
// conv5x5_clamp_histogram_top
// 5x5 sharpening filter over a raster pixel stream, clamped to 0..255, with a
// saturating 256-bin histogram of the results that can be read back.
// ----------------------------------------------------------------------------
// Takes one item per clock, pixel pushes and bin reads alike, and never
// stalls on its own: the only thing that holds the input is a result waiting
// in the output register. An item passes the line memory read, window, partial
// sum and histogram stages. Four previous rows sit in one line memory of
// MAX_WIDTH words, each word one column of all four rows, read as the pixel
// enters and written back from stage 1; a register window holds the 5x5
// neighborhood. The histogram is one memory read at one stage and written at
// the next, with a bypass for back-to-back hits on the same bin; per-bin valid
// bits clear it at reset, so no clearing pass is needed. A register write
// restarts the frame at row 0, column 0; write only while the block is idle.
// Pixels in the first four rows or columns of a frame give no result.
`default_nettype none

module conv5x5_clamp_histogram_top #(
  parameter int MAX_WIDTH = 512
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire cch_pkg::in_t               in_item,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output cch_pkg::out_t                   out_item,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [cch_pkg::CFG_W-1:0]  cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int EW     = (WW > cch_pkg::WREG_W) ? WW : cch_pkg::WREG_W;
  localparam int LINE_W = cch_pkg::LINES * cch_pkg::PIX_W;
  localparam int SUM_W  = 12;

  // Configuration and position
  logic [cch_pkg::WREG_W-1:0] width_reg;
  logic [cch_pkg::HREG_W-1:0] height_reg;
  logic [EW-1:0]              width_ext;
  logic [EW-1:0]              width_eff;
  logic [CW-1:0]              w_last;
  logic [cch_pkg::ROW_W-1:0]  h_last;
  logic [CW-1:0]              col_cnt;
  logic [cch_pkg::ROW_W-1:0]  row_cnt;

  logic adv;
  logic in_fire;
  logic push_fire;

  // Stage 1: line memory read data
  logic                        s1_valid;
  cch_pkg::cmd_t               s1_cmd;
  logic [cch_pkg::PIX_W-1:0]   s1_pix;
  logic [cch_pkg::BIN_W-1:0]   s1_bidx;
  logic                        s1_prod;
  logic [cch_pkg::ROW_W-1:0]   s1_row;
  logic [cch_pkg::COL_W-1:0]   s1_col;
  logic                        s1_fend;
  logic [CW-1:0]               s1_addr;
  logic [LINE_W-1:0]           line_q;
  logic [LINE_W-1:0]           line_mem [MAX_WIDTH];

  // Stage 2: window
  logic                        s2_valid;
  cch_pkg::cmd_t               s2_cmd;
  logic [cch_pkg::BIN_W-1:0]   s2_bidx;
  logic                        s2_prod;
  logic [cch_pkg::ROW_W-1:0]   s2_row;
  logic [cch_pkg::COL_W-1:0]   s2_col;
  logic                        s2_fend;
  logic [cch_pkg::PIX_W-1:0]   win [cch_pkg::KSIZE][cch_pkg::KSIZE];
  logic [SUM_W-1:0]            ring2;
  logic [SUM_W-1:0]            ring1;
  logic [SUM_W-1:0]            neg_sum;

  // Stage 3: partial sums
  logic                        s3_valid;
  cch_pkg::cmd_t               s3_cmd;
  logic [cch_pkg::BIN_W-1:0]   s3_bidx;
  logic                        s3_prod;
  logic [cch_pkg::ROW_W-1:0]   s3_row;
  logic [cch_pkg::COL_W-1:0]   s3_col;
  logic                        s3_fend;
  logic [cch_pkg::PIX_W-1:0]   s3_center;
  logic [SUM_W-1:0]            s3_neg;
  logic signed [SUM_W:0]       diff;
  logic [cch_pkg::PIX_W-1:0]   clamped;
  cch_pkg::hist_req_t          hreq;

  // Stage 4: histogram data
  logic                        s4_valid;
  cch_pkg::cmd_t               s4_cmd;
  logic                        s4_prod;
  logic [cch_pkg::ROW_W-1:0]   s4_row;
  logic [cch_pkg::COL_W-1:0]   s4_col;
  logic                        s4_fend;
  logic [cch_pkg::PIX_W-1:0]   s4_pix;
  logic [cch_pkg::CNT_W-1:0]   bin_cnt;
  cch_pkg::out_t               out_next;

  // Effective frame size: width clamped to 5..MAX_WIDTH, height to at least 5
  always_comb begin
    width_ext = EW'(width_reg);
    if (width_ext < EW'(cch_pkg::MIN_DIM)) begin
      width_eff = EW'(cch_pkg::MIN_DIM);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    w_last = CW'(width_eff - EW'(1));
    if (height_reg < cch_pkg::HREG_W'(cch_pkg::MIN_DIM)) begin
      h_last = cch_pkg::ROW_W'(cch_pkg::MIN_DIM - 1);
    end else begin
      h_last = height_reg - cch_pkg::ROW_W'(1);
    end
  end

  // Handshake: the whole pipe moves unless a result waits
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign in_fire   = in_valid && adv;
  assign push_fire = in_fire && (in_item.command == cch_pkg::CMD_PUSH);

  // Registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= cch_pkg::WIDTH_RESET;
      height_reg <= cch_pkg::HEIGHT_RESET;
      col_cnt    <= '0;
      row_cnt    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == cch_pkg::REG_WIDTH) begin
        width_reg <= cfg_data[cch_pkg::WREG_W-1:0];
      end else begin
        height_reg <= cfg_data[cch_pkg::HREG_W-1:0];
      end
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (push_fire) begin
      if (col_cnt == w_last) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == h_last) ? '0 : row_cnt + cch_pkg::ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // Line memory: read the column on entry, write it back shifted up a row
  always_ff @(posedge clk) begin
    if (adv) begin
      line_q <= line_mem[col_cnt];
      if (s1_valid && s1_cmd == cch_pkg::CMD_PUSH) begin
        line_mem[s1_addr] <= {s1_pix, line_q[LINE_W-1:cch_pkg::PIX_W]};
      end
    end
  end

  // Window: shift left, new column enters on the right
  always_ff @(posedge clk) begin
    if (adv && s1_valid && s1_cmd == cch_pkg::CMD_PUSH) begin
      for (int k = 0; k < cch_pkg::KSIZE; k++) begin
        for (int x = 0; x < cch_pkg::KSIZE - 1; x++) begin
          win[k][x] <= win[k][x+1];
        end
      end
      for (int k = 0; k < cch_pkg::LINES; k++) begin
        win[k][cch_pkg::KSIZE-1] <= line_q[k*cch_pkg::PIX_W +: cch_pkg::PIX_W];
      end
      win[cch_pkg::LINES][cch_pkg::KSIZE-1] <= s1_pix;
    end
  end

  // Negative kernel terms: inner ring weighs 2, outer ring 1
  always_comb begin
    ring2 = SUM_W'(win[1][2]) + SUM_W'(win[2][1]) + SUM_W'(win[2][3])
          + SUM_W'(win[3][2]);
    ring1 = SUM_W'(win[0][2]) + SUM_W'(win[1][1]) + SUM_W'(win[1][3])
          + SUM_W'(win[2][0]) + SUM_W'(win[2][4]) + SUM_W'(win[3][1])
          + SUM_W'(win[3][3]) + SUM_W'(win[4][2]);
    neg_sum = {ring2[SUM_W-2:0], 1'b0} + ring1;
  end

  // Center times 16 minus the rings, clamped; choose the bin to touch
  always_comb begin
    diff = $signed({1'b0, s3_center, 4'b0000}) - $signed({1'b0, s3_neg});
    if (diff < 0) begin
      clamped = '0;
    end else if (diff > $signed((SUM_W+1)'(255))) begin
      clamped = '1;
    end else begin
      clamped = diff[cch_pkg::PIX_W-1:0];
    end
    hreq.valid = s3_valid && (s3_cmd == cch_pkg::CMD_READ || s3_prod);
    hreq.incr  = (s3_cmd == cch_pkg::CMD_PUSH) && s3_prod;
    hreq.addr  = (s3_cmd == cch_pkg::CMD_READ) ? s3_bidx : clamped;
  end

  cch_hist u_hist (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .req   (hreq),
    .count (bin_cnt)
  );

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd  <= in_item.command;
      s1_pix  <= in_item.pixel;
      s1_bidx <= in_item.bin_index;
      s1_prod <= (row_cnt >= cch_pkg::ROW_W'(cch_pkg::MARGIN))
              && (col_cnt >= CW'(cch_pkg::MARGIN));
      s1_row  <= row_cnt - cch_pkg::ROW_W'(cch_pkg::MARGIN);
      s1_col  <= cch_pkg::COL_W'(col_cnt - CW'(cch_pkg::MARGIN));
      s1_fend <= (row_cnt == h_last) && (col_cnt == w_last);
      s1_addr <= col_cnt;

      s2_cmd  <= s1_cmd;
      s2_bidx <= s1_bidx;
      s2_prod <= s1_prod;
      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_fend <= s1_fend;

      s3_cmd    <= s2_cmd;
      s3_bidx   <= s2_bidx;
      s3_prod   <= s2_prod;
      s3_row    <= s2_row;
      s3_col    <= s2_col;
      s3_fend   <= s2_fend;
      s3_center <= win[2][2];
      s3_neg    <= neg_sum;

      s4_cmd  <= s3_cmd;
      s4_prod <= s3_prod;
      s4_row  <= s3_row;
      s4_col  <= s3_col;
      s4_fend <= s3_fend;
      s4_pix  <= clamped;

      out_item <= out_next;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid && (s4_cmd == cch_pkg::CMD_READ || s4_prod);
    end
  end

  // Format the result item
  always_comb begin
    if (s4_cmd == cch_pkg::CMD_READ) begin
      out_next.kind           = cch_pkg::KIND_BIN;
      out_next.filtered_pixel = '0;
      out_next.out_row        = '0;
      out_next.out_col        = '0;
      out_next.frame_end      = 1'b0;
      out_next.bin_count      = bin_cnt;
    end else begin
      out_next.kind           = cch_pkg::KIND_PIXEL;
      out_next.filtered_pixel = s4_pix;
      out_next.out_row        = s4_row;
      out_next.out_col        = s4_col;
      out_next.frame_end      = s4_fend;
      out_next.bin_count      = '0;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_col_in_row, clk, rst, 1'b1, col_cnt <= w_last && row_cnt <= h_last)
  `ASSERT_NEXT(a_cfg_restart, clk, rst, cfg_we, col_cnt == '0 && row_cnt == '0)
  `ASSERT_IMPLIES(a_frame_end_pos, clk, rst, out_valid && out_item.frame_end,
    out_item.out_col == cch_pkg::COL_W'(w_last - CW'(4))
    && out_item.out_row == h_last - cch_pkg::ROW_W'(4))
  `ASSERT_IMPLIES(a_bin_fields_zero, clk, rst, out_valid && out_item.kind == cch_pkg::KIND_BIN,
    out_item.filtered_pixel == '0 && out_item.out_row == '0 && !out_item.frame_end)

endmodule

`default_nettype wire
